### design/iqrs_pkg.sv
// Shared types and constants for the I/Q byte linear resampler.
`timescale 1ns / 1ps
`default_nettype none

package iqrs_pkg;

    localparam int DEF_OUT_PER_BLOCK      = 2048;
    localparam int DEF_MAX_SAMPLES_PER_MS = 16383;

    localparam int RAW_W      = 8;
    localparam int S_DATA_W   = 2 * RAW_W;
    localparam int SPM_W      = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SPM_W-1:0] SPM_RESET = SPM_W'(2500);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESAMPLE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_MS  = 1'd1;

    // Two neighbor samples and the block-end mark of one queued result
    typedef struct packed {
        logic signed [RAW_W-1:0] a_i;
        logic signed [RAW_W-1:0] a_q;
        logic signed [RAW_W-1:0] b_i;
        logic signed [RAW_W-1:0] b_q;
        logic                    last;
    } iqrs_pair_t;

endpackage

`default_nettype wire

### design/iqrs_front.sv
// Front end: configuration, block bookkeeping and classification of each input pair.
`timescale 1ns / 1ps
`default_nettype none

module iqrs_front import iqrs_pkg::*; #(
    parameter int OUT_PER_BLOCK      = DEF_OUT_PER_BLOCK,
    parameter int MAX_SAMPLES_PER_MS = DEF_MAX_SAMPLES_PER_MS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]               cfg_index,
    input  wire logic [SPM_W-1:0]                   cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [S_DATA_W-1:0]                s_tdata,   // raw_i, raw_q
    output logic                                    q_valid,
    input  wire logic                               q_ready,
    output iqrs_pair_t                              q_pair,
    output logic [$clog2(OUT_PER_BLOCK)-1:0]        q_frac
);

    localparam int FRAC_W = $clog2(OUT_PER_BLOCK);
    localparam int NW     = $clog2(MAX_SAMPLES_PER_MS + 1);
    localparam int CNT_W  = $clog2(OUT_PER_BLOCK + 1);
    localparam int POS_W  = FRAC_W + NW;
    localparam int EXT_W  = (NW > SPM_W) ? NW : SPM_W;

    logic                    enable_reg;
    logic [SPM_W-1:0]        spm_reg;
    logic signed [RAW_W-1:0] prev_i_reg, prev_i_next;
    logic signed [RAW_W-1:0] prev_q_reg, prev_q_next;
    logic [NW-1:0]           slot_reg, slot_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [POS_W-1:0]        pos_reg, pos_next;

    logic [EXT_W-1:0]        spm_ext;
    logic [EXT_W-1:0]        n_ext;
    logic [NW-1:0]           n;
    logic [NW-1:0]           base;
    logic [NW:0]             slot_inc;
    logic signed [RAW_W-1:0] cur_i, cur_q;
    logic                    in_fire;
    logic                    produce;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            spm_reg    <= SPM_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_RESAMPLE_ENABLE: enable_reg <= cfg_data[0];
                REG_SAMPLES_PER_MS:  spm_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the block size into the supported range
    always_comb begin
        spm_ext = EXT_W'(spm_reg);
        if (spm_ext < EXT_W'(OUT_PER_BLOCK + 1)) begin
            n_ext = EXT_W'(OUT_PER_BLOCK + 1);
        end else if (spm_ext > EXT_W'(MAX_SAMPLES_PER_MS)) begin
            n_ext = EXT_W'(MAX_SAMPLES_PER_MS);
        end else begin
            n_ext = spm_ext;
        end
        n = n_ext[NW-1:0];
    end

    // Offset binary to two's complement: flip the top bit
    assign cur_i = $signed({~s_tdata[RAW_W-1], s_tdata[RAW_W-2:0]});
    assign cur_q = $signed({~s_tdata[S_DATA_W-1], s_tdata[S_DATA_W-2:RAW_W]});

    assign base     = pos_reg[POS_W-1:FRAC_W];
    assign slot_inc = {1'b0, slot_reg} + 1'b1;
    assign s_tready = q_ready;
    assign in_fire  = s_tvalid && s_tready;
    assign produce  = !enable_reg ||
                      (count_reg < CNT_W'(OUT_PER_BLOCK) && base < slot_reg);
    assign q_valid  = in_fire && produce;

    always_comb begin
        if (enable_reg) begin
            q_pair.a_i  = prev_i_reg;
            q_pair.a_q  = prev_q_reg;
            q_pair.b_i  = cur_i;
            q_pair.b_q  = cur_q;
            q_pair.last = (count_reg == CNT_W'(OUT_PER_BLOCK - 1));
            q_frac      = pos_reg[FRAC_W-1:0];
        end else begin
            // Zero fraction puts the full weight on the current sample
            q_pair.a_i  = cur_i;
            q_pair.a_q  = cur_q;
            q_pair.b_i  = cur_i;
            q_pair.b_q  = cur_q;
            q_pair.last = 1'b0;
            q_frac      = '0;
        end
    end

    always_comb begin
        prev_i_next = prev_i_reg;
        prev_q_next = prev_q_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        if (in_fire) begin
            prev_i_next = cur_i;
            prev_q_next = cur_q;
            if (!enable_reg) begin
                slot_next  = '0;
                count_next = '0;
                pos_next   = '0;
            end else begin
                if (produce) begin
                    count_next = count_reg + 1'b1;
                    pos_next   = pos_reg + POS_W'(n);
                end
                // Close the block; its last sample seeds slot 0 of the next
                if (slot_inc > {1'b0, n}) begin
                    slot_next  = NW'(1);
                    count_next = '0;
                    pos_next   = '0;
                end else begin
                    slot_next = slot_inc[NW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_i_reg <= -8'sd128;
            prev_q_reg <= -8'sd128;
            slot_reg   <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
        end else begin
            prev_i_reg <= prev_i_next;
            prev_q_reg <= prev_q_next;
            slot_reg   <= slot_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
        end
    end

    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (s_tvalid && s_tready))
        else $error("queue push without an input transaction");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(OUT_PER_BLOCK))
        else $error("output count ran past the block");

    a_block_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && enable_reg && slot_inc > {1'b0, n}) |=> (slot_reg == NW'(1)))
        else $error("block did not restart at slot one");

endmodule

`default_nettype wire

### design/iqrs_queue.sv
// Short queue between the front end and the interpolation back end.
`timescale 1ns / 1ps
`default_nettype none

module iqrs_queue import iqrs_pkg::*; #(
    parameter int FRAC_W = 11
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    output logic                   push_ready,
    input  wire iqrs_pair_t        push_pair,
    input  wire logic [FRAC_W-1:0] push_frac,
    output logic                   head_valid,
    input  wire logic              pop,
    output iqrs_pair_t             head_pair,
    output logic [FRAC_W-1:0]      head_frac
);

    localparam int ENTRY_W = $bits(iqrs_pair_t) + FRAC_W;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               full;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push_ready = !full;
    assign head_valid = (count_reg != '0);
    assign {head_frac, head_pair} = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= {push_frac, push_pair};
        end
    end

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from an empty queue");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with fill count");

endmodule

`default_nettype wire

### design/iqrs_back.sv
// Back end: weights the two neighbor samples and holds the result for the output channel.
`timescale 1ns / 1ps
`default_nettype none

module iqrs_back import iqrs_pkg::*; #(
    parameter int OUT_PER_BLOCK = DEF_OUT_PER_BLOCK
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        head_valid,
    output logic                                             pop,
    input  wire iqrs_pair_t                                  head_pair,
    input  wire logic [$clog2(OUT_PER_BLOCK)-1:0]            head_frac,
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    output logic [((2*(RAW_W+$clog2(OUT_PER_BLOCK))+7)/8)*8-1:0] m_tdata, // out_i, out_q
    output logic                                             m_tlast   // block_end
);

    localparam int FRAC_W   = $clog2(OUT_PER_BLOCK);
    localparam int OUT_W    = RAW_W + FRAC_W;
    localparam int PW       = RAW_W + FRAC_W + 2;
    localparam int M_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

    logic [FRAC_W:0]         wa;
    logic signed [PW-1:0]    prod_a_i, prod_a_q, prod_b_i, prod_b_q;
    logic signed [PW:0]      sum_i, sum_q;
    logic                    valid_reg;
    logic [OUT_W-1:0]        out_i_reg, out_q_reg;
    logic                    last_reg;

    assign wa       = (FRAC_W + 1)'(OUT_PER_BLOCK) - {1'b0, head_frac};
    assign prod_a_i = head_pair.a_i * $signed({1'b0, wa});
    assign prod_a_q = head_pair.a_q * $signed({1'b0, wa});
    assign prod_b_i = head_pair.b_i * $signed({2'b00, head_frac});
    assign prod_b_q = head_pair.b_q * $signed({2'b00, head_frac});
    assign sum_i    = prod_a_i + prod_b_i;
    assign sum_q    = prod_a_q + prod_b_q;

    // Advance when the output register is empty or being drained
    assign pop = head_valid && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_i_reg <= sum_i[OUT_W-1:0];
            out_q_reg <= sum_q[OUT_W-1:0];
            last_reg  <= head_pair.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_DATA_W'({out_q_reg, out_i_reg});
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

### design/iq_byte_linear_resampler.sv
// Top level of the I/Q byte linear resampler.
`timescale 1ns / 1ps
`default_nettype none

// Converts 8-bit offset-binary I/Q pairs to signed samples. With resampling
// off, every pair comes out scaled by OUT_PER_BLOCK. With it on, the input is
// cut into blocks of N+1 samples (the last one seeds the next block) and
// OUT_PER_BLOCK linearly interpolated pairs per block come out at positions
// j*N/OUT_PER_BLOCK; m_tlast marks the last of a block. OUT_PER_BLOCK must be
// a power of two. One input pair is taken every clock while the queue is not
// full; each result passes through the four-entry queue and then the output register.
// Write the configuration only while no transaction is in flight.

module iq_byte_linear_resampler import iqrs_pkg::*; #(
    parameter int OUT_PER_BLOCK      = DEF_OUT_PER_BLOCK,
    parameter int MAX_SAMPLES_PER_MS = DEF_MAX_SAMPLES_PER_MS
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        cfg_valid,
    output logic                                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]                        cfg_index,
    input  wire logic [SPM_W-1:0]                            cfg_data,
    input  wire logic                                        s_tvalid,
    output logic                                             s_tready,
    input  wire logic [S_DATA_W-1:0]                         s_tdata,  // raw_i, raw_q
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    output logic [((2*(RAW_W+$clog2(OUT_PER_BLOCK))+7)/8)*8-1:0] m_tdata, // out_i, out_q
    output logic                                             m_tlast   // block_end
);

    localparam int FRAC_W = $clog2(OUT_PER_BLOCK);

    logic              q_valid;
    logic              q_ready;
    iqrs_pair_t        q_pair;
    logic [FRAC_W-1:0] q_frac;
    logic              head_valid;
    logic              pop;
    iqrs_pair_t        head_pair;
    logic [FRAC_W-1:0] head_frac;

    iqrs_front #(
        .OUT_PER_BLOCK      (OUT_PER_BLOCK),
        .MAX_SAMPLES_PER_MS (MAX_SAMPLES_PER_MS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_pair    (q_pair),
        .q_frac    (q_frac)
    );

    iqrs_queue #(
        .FRAC_W (FRAC_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_valid),
        .push_ready (q_ready),
        .push_pair  (q_pair),
        .push_frac  (q_frac),
        .head_valid (head_valid),
        .pop        (pop),
        .head_pair  (head_pair),
        .head_frac  (head_frac)
    );

    iqrs_back #(
        .OUT_PER_BLOCK (OUT_PER_BLOCK)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .pop        (pop),
        .head_pair  (head_pair),
        .head_frac  (head_frac),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
